@@ rtl/qrs_pkg.sv @@
// Shared widths, status codes and stage tags for the quadratic root solver.
package qrs_pkg;

  localparam int COEF_W    = 16;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int DISC_W    = PROD_W + 3;
  localparam int MAG_W     = DISC_W - 1;
  localparam int RAD_W     = 64;
  localparam int SQ_STAGES = RAD_W / 2;
  localparam int ROOT_W    = SQ_STAGES;
  localparam int SQREM_W   = ROOT_W + 2;
  localparam int BS_W      = 32;
  localparam int BS_SHIFT  = 15;
  localparam int SNUM_W    = ROOT_W + 2;
  localparam int NMAG_W    = SNUM_W - 1;
  localparam int NUM_W     = NMAG_W + 2;
  localparam int DEN_W     = COEF_W + 1;
  localparam int Q_W       = NUM_W;
  localparam int OUT_W     = 32;

  typedef enum logic [1:0] {
    ST_INVALID  = 2'd0,
    ST_TWO_REAL = 2'd1,
    ST_DOUBLE   = 2'd2,
    ST_COMPLEX  = 2'd3
  } status_t;

  typedef struct packed {
    status_t                    status;
    logic signed [COEF_W-1:0]   a;
    logic signed [BS_W-1:0]     bs;
  } sq_tag_t;

endpackage

@@ rtl/quadratic_root_solver.sv @@
// Pipelined quadratic root solver: discriminant, square root and two dividers.
//
// Pulse start with in_coef_a, in_coef_b and in_coef_c (signed, shared fraction
// point) to start one transfer; it is taken at any edge where busy is low, and
// busy is never raised, so a new coefficient set may enter in every cycle.
// Each result shows on out_status, out_first_value and out_second_value for
// exactly one cycle with out_valid high.
// Throughput is one item per cycle for any pattern of starts.
// The pipeline has one input register, one multiplier stage, one
// discriminant stage, 32 square root stages (one root bit each), two
// numerator stages and 35 divider stages (one quotient bit each), plus the
// output register. Both dividers run side by side.
// Roots are signed Q16.16, rounded to nearest with ties away from zero and
// saturated. A zero quadratic coefficient gives status 0 and zero roots.
// Synchronous reset clears all valid bits; items in flight are dropped.
// The receiver cannot stall, so there is no back pressure inside the block.
module quadratic_root_solver (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [qrs_pkg::COEF_W-1:0]  in_coef_a,
  input  logic signed [qrs_pkg::COEF_W-1:0]  in_coef_b,
  input  logic signed [qrs_pkg::COEF_W-1:0]  in_coef_c,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic signed [qrs_pkg::OUT_W-1:0]   out_first_value,
  output logic signed [qrs_pkg::OUT_W-1:0]   out_second_value
);

  localparam int SQ_N  = qrs_pkg::SQ_STAGES;
  localparam int DV_N  = qrs_pkg::Q_W;
  localparam int S3_TO_OUT = SQ_N + 2 + DV_N + 1;

  assign busy = 1'b0;

  // Input register.
  logic                              s1_valid_r;
  logic signed [qrs_pkg::COEF_W-1:0] s1_a_r, s1_b_r, s1_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
    s1_a_r <= in_coef_a;
    s1_b_r <= in_coef_b;
    s1_c_r <= in_coef_c;
  end

  // Products.
  logic                              s2_valid_r;
  logic signed [qrs_pkg::PROD_W-1:0] s2_bb_r, s2_ac_r;
  logic signed [qrs_pkg::COEF_W-1:0] s2_a_r, s2_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_bb_r <= s1_b_r * s1_b_r;
    s2_ac_r <= s1_a_r * s1_c_r;
    s2_a_r  <= s1_a_r;
    s2_b_r  <= s1_b_r;
  end

  // Discriminant and classification.
  logic signed [qrs_pkg::DISC_W-1:0] disc;
  logic [qrs_pkg::MAG_W-1:0]         s3_mag_nxt;
  qrs_pkg::sq_tag_t                  s3_tag_nxt;

  always_comb begin
    disc = qrs_pkg::DISC_W'(s2_bb_r) - (qrs_pkg::DISC_W'(s2_ac_r) <<< 2);
    s3_mag_nxt = disc[qrs_pkg::DISC_W-1] ? qrs_pkg::MAG_W'(-disc)
                                         : qrs_pkg::MAG_W'(disc);
    s3_tag_nxt.a  = s2_a_r;
    s3_tag_nxt.bs = -(qrs_pkg::BS_W'(s2_b_r) <<< qrs_pkg::BS_SHIFT);
    if (s2_a_r == '0) begin
      s3_tag_nxt.status = qrs_pkg::ST_INVALID;
    end else if (disc[qrs_pkg::DISC_W-1]) begin
      s3_tag_nxt.status = qrs_pkg::ST_COMPLEX;
    end else if (disc == '0) begin
      s3_tag_nxt.status = qrs_pkg::ST_DOUBLE;
    end else begin
      s3_tag_nxt.status = qrs_pkg::ST_TWO_REAL;
    end
  end

  logic                      s3_valid_r;
  logic [qrs_pkg::MAG_W-1:0] s3_mag_r;
  qrs_pkg::sq_tag_t          s3_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_mag_r <= s3_mag_nxt;
    s3_tag_r <= s3_tag_nxt;
  end

  // Square root, one result bit per stage, radicand is |D| shifted up by 30.
  logic                        sq_valid_in [SQ_N];
  logic [qrs_pkg::RAD_W-1:0]   sq_rad_in   [SQ_N];
  logic [qrs_pkg::SQREM_W-1:0] sq_rem_in   [SQ_N];
  logic [qrs_pkg::ROOT_W-1:0]  sq_root_in  [SQ_N];
  qrs_pkg::sq_tag_t            sq_tag_in   [SQ_N];
  logic                        sq_valid_r  [SQ_N];
  logic [qrs_pkg::RAD_W-1:0]   sq_rad_r    [SQ_N];
  logic [qrs_pkg::SQREM_W-1:0] sq_rem_r    [SQ_N];
  logic [qrs_pkg::ROOT_W-1:0]  sq_root_r   [SQ_N];
  qrs_pkg::sq_tag_t            sq_tag_r    [SQ_N];

  assign sq_valid_in[0] = s3_valid_r;
  assign sq_rad_in[0]   = {s3_mag_r, (qrs_pkg::RAD_W - qrs_pkg::MAG_W)'(0)};
  assign sq_rem_in[0]   = '0;
  assign sq_root_in[0]  = '0;
  assign sq_tag_in[0]   = s3_tag_r;

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    logic [qrs_pkg::SQREM_W+1:0] rem_sh, trial;
    logic                        ge;
    logic [qrs_pkg::SQREM_W-1:0] sq_rem_nxt;
    logic [qrs_pkg::ROOT_W-1:0]  sq_root_nxt;

    if (k > 0) begin : g_link
      assign sq_valid_in[k] = sq_valid_r[k-1];
      assign sq_rad_in[k]   = sq_rad_r[k-1];
      assign sq_rem_in[k]   = sq_rem_r[k-1];
      assign sq_root_in[k]  = sq_root_r[k-1];
      assign sq_tag_in[k]   = sq_tag_r[k-1];
    end

    always_comb begin
      rem_sh = {sq_rem_in[k], sq_rad_in[k][2*(SQ_N-1-k) +: 2]};
      trial  = {2'b00, sq_root_in[k], 2'b01};
      ge     = rem_sh >= trial;
      sq_rem_nxt  = ge ? qrs_pkg::SQREM_W'(rem_sh - trial) : qrs_pkg::SQREM_W'(rem_sh);
      sq_root_nxt = {sq_root_in[k][qrs_pkg::ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_valid_r[k] <= 1'b0;
      end else begin
        sq_valid_r[k] <= sq_valid_in[k];
      end
      sq_rad_r[k]  <= sq_rad_in[k];
      sq_rem_r[k]  <= sq_rem_nxt;
      sq_root_r[k] <= sq_root_nxt;
      sq_tag_r[k]  <= sq_tag_in[k];
    end
  end

  // Signed numerators for both roots.
  qrs_pkg::sq_tag_t                  sq_last;
  logic signed [qrs_pkg::SNUM_W-1:0] bs_ext, root_ext;
  logic signed [qrs_pkg::SNUM_W-1:0] p1_num0_nxt, p1_num1_nxt;

  assign sq_last = sq_tag_r[SQ_N-1];

  always_comb begin
    bs_ext   = qrs_pkg::SNUM_W'(sq_last.bs);
    root_ext = $signed({2'b00, sq_root_r[SQ_N-1]});
    case (sq_last.status)
      qrs_pkg::ST_TWO_REAL: begin
        p1_num0_nxt = bs_ext + root_ext;
        p1_num1_nxt = bs_ext - root_ext;
      end
      qrs_pkg::ST_COMPLEX: begin
        p1_num0_nxt = bs_ext;
        p1_num1_nxt = root_ext;
      end
      default: begin
        p1_num0_nxt = bs_ext;
        p1_num1_nxt = bs_ext;
      end
    endcase
  end

  logic                              p1_valid_r;
  logic signed [qrs_pkg::SNUM_W-1:0] p1_num0_r, p1_num1_r;
  logic signed [qrs_pkg::COEF_W-1:0] p1_a_r;
  qrs_pkg::status_t                  p1_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= sq_valid_r[SQ_N-1];
    end
    p1_num0_r   <= p1_num0_nxt;
    p1_num1_r   <= p1_num1_nxt;
    p1_a_r      <= sq_last.a;
    p1_status_r <= sq_last.status;
  end

  // Magnitudes: rounding numerator 2|N|+|a| over divisor 2|a|.
  logic [qrs_pkg::COEF_W-1:0] a_mag;
  logic [qrs_pkg::NMAG_W-1:0] n0_mag, n1_mag;

  always_comb begin
    a_mag  = p1_a_r[qrs_pkg::COEF_W-1] ? qrs_pkg::COEF_W'(-p1_a_r) : qrs_pkg::COEF_W'(p1_a_r);
    n0_mag = p1_num0_r[qrs_pkg::SNUM_W-1] ? qrs_pkg::NMAG_W'(-p1_num0_r)
                                          : qrs_pkg::NMAG_W'(p1_num0_r);
    n1_mag = p1_num1_r[qrs_pkg::SNUM_W-1] ? qrs_pkg::NMAG_W'(-p1_num1_r)
                                          : qrs_pkg::NMAG_W'(p1_num1_r);
  end

  logic                       p2_valid_r;
  logic [qrs_pkg::NUM_W-1:0]  p2_num_r [2];
  logic                       p2_neg_r [2];
  logic [qrs_pkg::DEN_W-1:0]  p2_den_r;
  qrs_pkg::status_t           p2_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else begin
      p2_valid_r <= p1_valid_r;
    end
    p2_num_r[0] <= {n0_mag, 1'b0} + qrs_pkg::NUM_W'(a_mag);
    p2_num_r[1] <= {n1_mag, 1'b0} + qrs_pkg::NUM_W'(a_mag);
    p2_neg_r[0] <= p1_num0_r[qrs_pkg::SNUM_W-1] ^ p1_a_r[qrs_pkg::COEF_W-1];
    p2_neg_r[1] <= p1_num1_r[qrs_pkg::SNUM_W-1] ^ p1_a_r[qrs_pkg::COEF_W-1];
    p2_den_r    <= {a_mag, 1'b0};
    p2_status_r <= p1_status_r;
  end

  // Two restoring dividers, one quotient bit per stage.
  logic                      dv_valid_in  [DV_N];
  logic [qrs_pkg::DEN_W-1:0] dv_den_in    [DV_N];
  qrs_pkg::status_t          dv_status_in [DV_N];
  logic                      dv_valid_r   [DV_N];
  logic [qrs_pkg::DEN_W-1:0] dv_den_r     [DV_N];
  qrs_pkg::status_t          dv_status_r  [DV_N];
  logic [qrs_pkg::NUM_W-1:0] dv_num_in    [DV_N][2];
  logic [qrs_pkg::DEN_W-1:0] dv_rem_in    [DV_N][2];
  logic [qrs_pkg::Q_W-1:0]   dv_quo_in    [DV_N][2];
  logic                      dv_neg_in    [DV_N][2];
  logic [qrs_pkg::NUM_W-1:0] dv_num_r     [DV_N][2];
  logic [qrs_pkg::DEN_W-1:0] dv_rem_r     [DV_N][2];
  logic [qrs_pkg::Q_W-1:0]   dv_quo_r     [DV_N][2];
  logic                      dv_neg_r     [DV_N][2];

  for (genvar k = 0; k < DV_N; k++) begin : g_dv
    if (k == 0) begin : g_head
      assign dv_valid_in[k]  = p2_valid_r;
      assign dv_den_in[k]    = p2_den_r;
      assign dv_status_in[k] = p2_status_r;
    end else begin : g_link
      assign dv_valid_in[k]  = dv_valid_r[k-1];
      assign dv_den_in[k]    = dv_den_r[k-1];
      assign dv_status_in[k] = dv_status_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[k] <= 1'b0;
      end else begin
        dv_valid_r[k] <= dv_valid_in[k];
      end
      dv_den_r[k]    <= dv_den_in[k];
      dv_status_r[k] <= dv_status_in[k];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [qrs_pkg::DEN_W:0]   rem_sh;
      logic                      ge;
      logic [qrs_pkg::DEN_W-1:0] dv_rem_nxt;
      logic [qrs_pkg::Q_W-1:0]   dv_quo_nxt;

      if (k == 0) begin : g_head
        assign dv_num_in[k][l] = p2_num_r[l];
        assign dv_rem_in[k][l] = '0;
        assign dv_quo_in[k][l] = '0;
        assign dv_neg_in[k][l] = p2_neg_r[l];
      end else begin : g_link
        assign dv_num_in[k][l] = dv_num_r[k-1][l];
        assign dv_rem_in[k][l] = dv_rem_r[k-1][l];
        assign dv_quo_in[k][l] = dv_quo_r[k-1][l];
        assign dv_neg_in[k][l] = dv_neg_r[k-1][l];
      end

      always_comb begin
        rem_sh     = {dv_rem_in[k][l], dv_num_in[k][l][DV_N-1-k]};
        ge         = rem_sh >= {1'b0, dv_den_in[k]};
        dv_rem_nxt = ge ? qrs_pkg::DEN_W'(rem_sh - {1'b0, dv_den_in[k]})
                        : qrs_pkg::DEN_W'(rem_sh);
        dv_quo_nxt = {dv_quo_in[k][l][qrs_pkg::Q_W-2:0], ge};
      end

      always_ff @(posedge clk) begin
        dv_num_r[k][l] <= dv_num_in[k][l];
        dv_rem_r[k][l] <= dv_rem_nxt;
        dv_quo_r[k][l] <= dv_quo_nxt;
        dv_neg_r[k][l] <= dv_neg_in[k][l];
      end
    end
  end

  // Sign and saturation to Q16.16.
  function automatic logic [qrs_pkg::OUT_W-1:0] saturate(
    input logic [qrs_pkg::Q_W-1:0] quo,
    input logic                    neg
  );
    logic [qrs_pkg::OUT_W-1:0] res;
    if (neg) begin
      res = (quo >= (qrs_pkg::Q_W'(1) << (qrs_pkg::OUT_W - 1)))
            ? {1'b1, (qrs_pkg::OUT_W-1)'(0)} : qrs_pkg::OUT_W'(-quo);
    end else begin
      res = (quo >= (qrs_pkg::Q_W'(1) << (qrs_pkg::OUT_W - 1)))
            ? {1'b0, {(qrs_pkg::OUT_W-1){1'b1}}} : qrs_pkg::OUT_W'(quo);
    end
    return res;
  endfunction

  logic                      dv_last_invalid;
  logic [qrs_pkg::OUT_W-1:0] out_first_nxt, out_second_nxt;

  always_comb begin
    dv_last_invalid = dv_status_r[DV_N-1] == qrs_pkg::ST_INVALID;
    out_first_nxt   = dv_last_invalid ? '0
                      : saturate(dv_quo_r[DV_N-1][0], dv_neg_r[DV_N-1][0]);
    out_second_nxt  = dv_last_invalid ? '0
                      : saturate(dv_quo_r[DV_N-1][1], dv_neg_r[DV_N-1][1]);
  end

  logic                             out_valid_r;
  qrs_pkg::status_t                 out_status_r;
  logic signed [qrs_pkg::OUT_W-1:0] out_first_r, out_second_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid_r[DV_N-1];
    end
    out_status_r <= dv_status_r[DV_N-1];
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_first_value  = out_first_r;
  assign out_second_value = out_second_r;

  // Every result comes from an item that left the discriminant stage in order.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(s3_valid_r, S3_TO_OUT))
    else $error("result without a matching item in the pipeline");

  a_invalid_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status_r == qrs_pkg::ST_INVALID) |->
      (out_first_value == '0 && out_second_value == '0))
    else $error("invalid equation gave nonzero roots");

  a_double_equal : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status_r == qrs_pkg::ST_DOUBLE) |->
      (out_first_value == out_second_value))
    else $error("double root gave two different values");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the pipelined quadratic root solver.
module tb_top;

  typedef struct packed {
    logic signed [qrs_pkg::COEF_W-1:0] a;
    logic signed [qrs_pkg::COEF_W-1:0] b;
    logic signed [qrs_pkg::COEF_W-1:0] c;
    logic                              drain;
  } coef_set_t;

  typedef struct packed {
    qrs_pkg::status_t                 status;
    logic signed [qrs_pkg::OUT_W-1:0] first;
    logic signed [qrs_pkg::OUT_W-1:0] second;
  } root_pair_t;

  localparam int LATENCY = 73;

  logic                              clk;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic signed [qrs_pkg::COEF_W-1:0] in_coef_a;
  logic signed [qrs_pkg::COEF_W-1:0] in_coef_b;
  logic signed [qrs_pkg::COEF_W-1:0] in_coef_c;
  logic                              out_valid;
  logic [1:0]                        out_status;
  logic signed [qrs_pkg::OUT_W-1:0]  out_first_value;
  logic signed [qrs_pkg::OUT_W-1:0]  out_second_value;

  coef_set_t  pending_sets[$];
  root_pair_t expected_roots[$];
  int         mismatch_count = 0;

  quadratic_root_solver u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_coef_a        (in_coef_a),
    .in_coef_b        (in_coef_b),
    .in_coef_c        (in_coef_c),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_first_value  (out_first_value),
    .out_second_value (out_second_value)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Rounded quotient, ties away from zero, clamped to the Q16.16 range.
  function automatic logic signed [qrs_pkg::OUT_W-1:0] round_div_sat(input longint num,
                                                                     input longint den);
    bit          neg;
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] q;
    neg = (num < 0) != (den < 0);
    n   = (num < 0) ? -num : num;
    d   = (den < 0) ? -den : den;
    q   = (2 * n + d) / (2 * d);
    if (neg) return (q >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
    return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
  endfunction

  function automatic root_pair_t solve_roots(input coef_set_t s);
    root_pair_t r;
    longint     a;
    longint     b;
    longint     c;
    longint     disc;
    longint     bs;
    longint     root;
    a = s.a;
    b = s.b;
    c = s.c;
    if (a == 0) begin
      r.status = qrs_pkg::ST_INVALID;
      r.first  = '0;
      r.second = '0;
      return r;
    end
    disc = b * b - 4 * a * c;
    bs   = -b * 32768;
    if (disc > 0) begin
      root     = int_sqrt(disc << 30);
      r.status = qrs_pkg::ST_TWO_REAL;
      r.first  = round_div_sat(bs + root, a);
      r.second = round_div_sat(bs - root, a);
    end else if (disc == 0) begin
      r.status = qrs_pkg::ST_DOUBLE;
      r.first  = round_div_sat(bs, a);
      r.second = r.first;
    end else begin
      root     = int_sqrt((-disc) << 30);
      r.status = qrs_pkg::ST_COMPLEX;
      r.first  = round_div_sat(bs, a);
      r.second = round_div_sat(root, a);
    end
    return r;
  endfunction

  function automatic logic signed [qrs_pkg::COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1:       return $signed(16'($urandom_range(0, 16))) - 16'sd8;
      2, 3:    return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
      default: return $signed(16'($urandom()));
    endcase
  endfunction

  task automatic add_set(input int a, input int b, input int c, input bit drain);
    coef_set_t s;
    s.a     = qrs_pkg::COEF_W'(a);
    s.b     = qrs_pkg::COEF_W'(b);
    s.c     = qrs_pkg::COEF_W'(c);
    s.drain = drain;
    pending_sets.push_back(s);
  endtask

  // Driver: takes sets from the queue, with random gaps between transfers.
  int gap_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      start     <= 1'b0;
      in_coef_a <= '0;
      in_coef_b <= '0;
      in_coef_c <= '0;
      gap_left  <= 0;
    end else if (start && busy) begin
      // Hold the current set until it is taken.
    end else if (gap_left > 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_sets.size() > 0 &&
                 !(pending_sets[0].drain && expected_roots.size() > 0)) begin
      coef_set_t s;
      s = pending_sets.pop_front();
      start     <= 1'b1;
      in_coef_a <= s.a;
      in_coef_b <= s.b;
      in_coef_c <= s.c;
      expected_roots.push_back(solve_roots(s));
      case ($urandom_range(0, 19))
        0:          gap_left <= $urandom_range(20, 120);
        1, 2, 3, 4: gap_left <= $urandom_range(1, 4);
        default:    gap_left <= 0;
      endcase
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_roots.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result: status %0d", out_status);
      end else begin
        root_pair_t e;
        e = expected_roots.pop_front();
        if (out_status !== e.status || out_first_value !== e.first ||
            out_second_value !== e.second) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     e.status, e.first, e.second,
                     out_status, out_first_value, out_second_value);
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    rst_n = 1'b0;

    // Directed sets: zero a, extremes, each root class, negative a.
    add_set(0, 256, 256, 0);
    add_set(0, -32768, 32767, 0);
    add_set(256, 0, -256, 0);
    add_set(256, -512, 256, 0);
    add_set(256, 0, 256, 0);
    add_set(-256, 0, -256, 0);
    add_set(-256, 512, 256, 0);
    add_set(256, 512, 1280, 0);
    add_set(32767, 32767, 32767, 0);
    add_set(-32768, -32768, -32768, 0);
    add_set(-32768, 32767, 32767, 0);
    add_set(32767, -32768, -32768, 0);
    add_set(1, -32768, 0, 0);
    add_set(1, 32767, -32768, 0);
    add_set(-1, -32768, 32767, 0);
    add_set(1, 0, 32767, 0);
    add_set(-1, 0, -32768, 0);
    add_set(1, 2, 1, 0);
    add_set(-32768, 0, 0, 0);
    add_set(3, 1, 0, 0);
    add_set(1, 1, 0, 0);
    // Random sets; some are built as exact squares for double roots.
    for (int i = 0; i < 800; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        int k;
        int m;
        k = $urandom_range(1, 90) * ($urandom_range(0, 1) ? 1 : -1);
        m = $signed(12'($urandom())) / 16;
        add_set(k * k, 2 * k * m, m * m, i == 400);
      end else begin
        add_set(rand_coef(), rand_coef(), rand_coef(), i == 400);
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_sets.size() == 0);
    @(posedge clk);
    while (start) @(posedge clk);
    wait (expected_roots.size() == 0);
    idle_cycles = 0;
    while (idle_cycles < 2 * LATENCY) begin
      @(posedge clk);
      idle_cycles++;
    end
    if (mismatch_count == 0 && expected_roots.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ quadratic_root_solver.f @@
rtl/qrs_pkg.sv
rtl/quadratic_root_solver.sv
tb/tb_top.sv
